>>> src/sif_pkg.sv
// shared types and constants for the spherical interface wall force core
// no dependencies; imported by every module of the block but sif_ram
`default_nettype none

package sif_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int NUM_TYPES_DEF = 8;

  localparam int POS_W    = 32;
  localparam int IDX_W    = 16;
  localparam int TYPE_W   = 3;
  localparam int RAD_W    = 31;
  localparam int R2_W     = 64;
  localparam int ROOT_W   = 32;
  localparam int DR_W     = 35;
  localparam int Q_W      = FRAC_BITS + 1;
  localparam int FORCE_W  = 32;
  localparam int ENERGY_W = 48;
  localparam int FV_W     = 49;
  localparam int EV_W     = 64;

  localparam int IN_DATA_W  = 248;
  localparam int OUT_DATA_W = 160;

  typedef enum logic {
    MODE_EVAL = 1'b0,
    MODE_LOAD = 1'b1
  } mode_t;

  typedef logic signed [POS_W-1:0] fix_t;

  typedef struct packed {
    fix_t k;
    fix_t off;
    fix_t g;
    fix_t cut;
  } prm_t;

  localparam int PRM_W = $bits(prm_t);

  // per-particle context carried down the pipeline
  typedef struct packed {
    logic [IDX_W-1:0]            idx;
    logic [2:0]                  neg;
    logic [2:0][POS_W-1:0]       pmag;
    logic                        on;
    prm_t                        prm;
    logic [ROOT_W-1:0]           r;
    logic                        live;
    logic                        harm;
    logic signed [DR_W-1:0]      dr;
  } ctx_t;

endpackage

`default_nettype wire

>>> src/sif_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module sif_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/sif_isqrt.sv
// pipelined integer square root, one result bit per stage
// depends on sif_pkg (ctx_t, widths)
`default_nettype none

module sif_isqrt import sif_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              vin,
  input  wire ctx_t              ctx_in,
  input  wire logic [R2_W-1:0]   rad_in,
  output logic                   vout,
  output ctx_t                   ctx_out,
  output logic [ROOT_W-1:0]      root_out
);

  localparam int NS    = ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic              v_q    [NS];
  ctx_t              ctx_q  [NS];
  logic [R2_W-1:0]   rad_q  [NS];
  logic [REM_W-1:0]  rem_q  [NS];
  logic [ROOT_W-1:0] root_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic              vin_s;
    ctx_t              ctx_s;
    logic [R2_W-1:0]   rad_s;
    logic [REM_W-1:0]  rem_s;
    logic [ROOT_W-1:0] root_s;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;

    if (s == 0) begin : g_first
      assign vin_s  = vin;
      assign ctx_s  = ctx_in;
      assign rad_s  = rad_in;
      assign rem_s  = '0;
      assign root_s = '0;
    end else begin : g_next
      assign vin_s  = v_q[s-1];
      assign ctx_s  = ctx_q[s-1];
      assign rad_s  = rad_q[s-1];
      assign rem_s  = rem_q[s-1];
      assign root_s = root_q[s-1];
    end

    assign rem_sh = {rem_s, rad_s[R2_W-1-2*s -: 2]};
    assign trial  = (REM_W+2)'({root_s, 2'b01});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else if (en) begin
        v_q[s] <= vin_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_q[s] <= ctx_s;
        rad_q[s] <= rad_s;
        if (rem_sh >= trial) begin
          rem_q[s]  <= REM_W'(rem_sh - trial);
          root_q[s] <= {root_s[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[s]  <= REM_W'(rem_sh);
          root_q[s] <= {root_s[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign vout     = v_q[NS-1];
  assign ctx_out  = ctx_q[NS-1];
  assign root_out = root_q[NS-1];

endmodule

`default_nettype wire

>>> src/sif_div.sv
// pipelined restoring divider, three lanes: (|pos| << FRAC_BITS) / r
// depends on sif_pkg (ctx_t, widths)
`default_nettype none

module sif_div import sif_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           vin,
  input  wire ctx_t           ctx_in,
  output logic                vout,
  output ctx_t                ctx_out,
  output logic [Q_W-1:0]      q_out [3]
);

  localparam int NS = Q_W;

  logic             v_q   [NS];
  ctx_t             ctx_q [NS];
  logic [POS_W-1:0] rem_q [NS][3];
  logic [Q_W-1:0]   qt_q  [NS][3];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic             vin_s;
    ctx_t             ctx_s;
    logic [POS_W-1:0] rem_s [3];
    logic [Q_W-1:0]   qt_s  [3];
    logic             nbit  [3];
    logic [POS_W:0]   rem_sh [3];
    logic [POS_W:0]   dv;

    // quotient fits q_w bits since |pos| <= r, so the dividend top starts below r
    if (s == 0) begin : g_first
      assign vin_s = vin;
      assign ctx_s = ctx_in;
      for (genvar c = 0; c < 3; c++) begin : g_lane
        assign rem_s[c] = {1'b0, ctx_in.pmag[c][POS_W-1:1]};
        assign qt_s[c]  = '0;
        assign nbit[c]  = ctx_in.pmag[c][0];
      end
    end else begin : g_next
      assign vin_s = v_q[s-1];
      assign ctx_s = ctx_q[s-1];
      for (genvar c = 0; c < 3; c++) begin : g_lane
        assign rem_s[c] = rem_q[s-1][c];
        assign qt_s[c]  = qt_q[s-1][c];
        assign nbit[c]  = 1'b0;
      end
    end

    assign dv = {1'b0, ctx_s.r};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else if (en) begin
        v_q[s] <= vin_s;
      end
    end

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        rem_sh[c] = {rem_s[c], nbit[c]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_q[s] <= ctx_s;
        for (int c = 0; c < 3; c++) begin
          if (rem_sh[c] >= dv) begin
            rem_q[s][c] <= POS_W'(rem_sh[c] - dv);
            qt_q[s][c]  <= {qt_s[c][Q_W-2:0], 1'b1};
          end else begin
            rem_q[s][c] <= POS_W'(rem_sh[c]);
            qt_q[s][c]  <= {qt_s[c][Q_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign vout    = v_q[NS-1];
  assign ctx_out = ctx_q[NS-1];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q_out[c] = qt_q[NS-1][c];
    end
  end

endmodule

`default_nettype wire

>>> src/sif_force.sv
// force and energy stages: products, shifts and signs, before clipping
// depends on sif_pkg (ctx_t, widths, FRAC_BITS)
`default_nettype none

module sif_force import sif_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    vin,
  input  wire ctx_t                    ctx_in,
  input  wire logic [Q_W-1:0]          q_in [3],
  output logic                         vout,
  output logic [IDX_W-1:0]             idx_out,
  output logic signed [FV_W-1:0]       force_out [3],
  output logic signed [EV_W-1:0]       energy_out
);

  localparam int FM_W = 47;
  localparam int T2_W = 50;
  localparam int EM_W = 61;

  // stage a
  logic               va;
  ctx_t               ctx_a;
  logic [Q_W-1:0]     q_a [3];
  logic [POS_W-1:0]   kmag_a, gmag_a;
  logic [61:0]        sq_a;
  logic [62:0]        kd_a;
  logic [65:0]        gl_a;
  // stage b
  logic               vb;
  ctx_t               ctx_b;
  logic [Q_W-1:0]     q_b [3];
  logic [FM_W-1:0]    fm_b;
  logic               fneg_b;
  logic [62:0]        pl_b, ph_b;
  logic [T2_W-1:0]    t2_b;
  // stage c
  logic               vc;
  ctx_t               ctx_c;
  logic               fneg_c;
  logic [63:0]        fp_c [3];
  logic [EM_W-1:0]    em_c;
  logic [T2_W-1:0]    t2_c;

  logic [POS_W-1:0]   kmag, gmag;
  logic [30:0]        drl, sqop;
  logic signed [DR_W-1:0] dmc;
  logic [93:0]        esum;
  logic [47:0]        fmm [3];
  logic signed [FV_W-1:0] fv [3];
  logic signed [EV_W-1:0] e1, t2s, ev;

  always_comb begin
    kmag = ctx_in.prm.k[POS_W-1] ? (~ctx_in.prm.k + 32'd1) : ctx_in.prm.k;
    gmag = ctx_in.prm.g[POS_W-1] ? (~ctx_in.prm.g + 32'd1) : ctx_in.prm.g;
    drl  = ctx_in.dr[30:0];
    // harmonic branch squares dr, linear branch squares the cutoff
    sqop = ctx_in.harm ? drl : ctx_in.prm.cut[30:0];
    dmc  = ctx_in.dr - $signed({{3{ctx_in.prm.cut[POS_W-1]}}, ctx_in.prm.cut});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      va <= vin;
      vb <= va;
      vc <= vb;
      vout <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_a  <= ctx_in;
      q_a    <= q_in;
      kmag_a <= kmag;
      gmag_a <= gmag;
      sq_a   <= sqop * sqop;
      kd_a   <= kmag * drl;
      gl_a   <= gmag * dmc[33:0];

      ctx_b  <= ctx_a;
      q_b    <= q_a;
      fm_b   <= ctx_a.harm ? FM_W'(kd_a >> FRAC_BITS) : FM_W'(gmag_a);
      fneg_b <= ctx_a.harm ? ctx_a.prm.k[POS_W-1] : ctx_a.prm.g[POS_W-1];
      pl_b   <= kmag_a * sq_a[30:0];
      ph_b   <= kmag_a * sq_a[61:31];
      t2_b   <= T2_W'(gl_a >> FRAC_BITS);

      ctx_c  <= ctx_b;
      fneg_c <= fneg_b;
      for (int c = 0; c < 3; c++) begin
        fp_c[c] <= fm_b * q_b[c];
      end
      em_c   <= EM_W'(esum >> (2 * FRAC_BITS + 1));
      t2_c   <= t2_b;

      idx_out    <= ctx_c.idx;
      force_out  <= fv;
      energy_out <= ev;
    end
  end

  assign esum = {31'd0, pl_b} + {ph_b, 31'd0};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      fmm[c] = 48'(fp_c[c] >> FRAC_BITS);
      // force points against the product sign
      if (!ctx_c.live) begin
        fv[c] = '0;
      end else if (fneg_c ^ ctx_c.neg[c]) begin
        fv[c] = $signed({1'b0, fmm[c]});
      end else begin
        fv[c] = -$signed({1'b0, fmm[c]});
      end
    end
    e1  = ctx_c.prm.k[POS_W-1] ? -$signed({3'b0, em_c}) : $signed({3'b0, em_c});
    t2s = ctx_c.prm.g[POS_W-1] ? -$signed({14'b0, t2_c}) : $signed({14'b0, t2_c});
    if (!ctx_c.live) begin
      ev = '0;
    end else if (ctx_c.harm) begin
      ev = e1;
    end else begin
      ev = e1 + t2s;
    end
  end

endmodule

`default_nettype wire

>>> src/spherical_interface_wall_force_core.sv
// top level of the spherical interface wall force core
// depends on sif_pkg, sif_ram, sif_isqrt, sif_div, sif_force
`default_nettype none

// Takes one request per cycle unless the pipe stalls and returns one result for every
// particle request (tuser = 0); table loads (tuser = 1) give no result and land in the
// per-type table at once, so the next request already sees them.
// The latency comes from the 32-stage square root and the 17-stage divider
// that make |pos| and the unit direction; the table is a small ram read in the
// accept cycle. A result waiting on the output does not stop intake until it
// reaches the pipeline tail. Types beyond NUM_TYPES, and types never loaded
// since reset, evaluate to zero force and zero energy.
module spherical_interface_wall_force_core import sif_pkg::*; #(
  parameter int NUM_TYPES = NUM_TYPES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // idx[15:0] type[18:16] pos_x[50:19] pos_y[82:51] pos_z[114:83]
  // spring_k[146:115] offset_dist[178:147] linear_force[210:179] cutoff_dist[242:211]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // mode[0]
  input  wire logic                  s_axis_tuser,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // result_index[15:0] force_x[47:16] force_y[79:48] force_z[111:80] energy[159:112]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // saturated[0]
  output logic                       m_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [RAD_W-1:0]      cfg_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready
);

  localparam int AW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

  logic [RAD_W-1:0]      radius;
  logic [NUM_TYPES-1:0]  vld;

  logic                  accept, adv, out_load;
  mode_t                 mode;
  logic [TYPE_W-1:0]     typ;
  logic                  type_ok, we;
  logic [AW-1:0]         addr;
  prm_t                  wprm, rprm;

  logic                  v1;
  logic [IDX_W-1:0]      idx1;
  fix_t                  pos1 [3];
  logic                  ok1;

  logic [POS_W-1:0]      pm [3];
  ctx_t                  ctx1;
  logic                  v2;
  ctx_t                  ctx2;
  logic [R2_W-1:0]       sq2 [3];
  logic                  v3;
  ctx_t                  ctx3;
  logic [R2_W-1:0]       r2_3;

  logic                  vs;
  ctx_t                  ctxs;
  logic [ROOT_W-1:0]     root_s;

  logic signed [DR_W-1:0] base_d, rootv_d, dr_d, cut_d;
  ctx_t                  ctxd_n;
  logic                  vd;
  ctx_t                  ctxd;

  logic                  vq;
  ctx_t                  ctxq;
  logic [Q_W-1:0]        qv [3];

  logic                  vf;
  logic [IDX_W-1:0]      idxf;
  logic signed [FV_W-1:0] ff [3];
  logic signed [EV_W-1:0] ef;

  logic [FORCE_W-1:0]    fclip [3];
  logic [2:0]            fsat;
  logic [ENERGY_W-1:0]   eclip;
  logic                  esat;

  assign mode    = mode_t'(s_axis_tuser);
  assign typ     = s_axis_tdata[18:16];
  assign type_ok = 32'(typ) < NUM_TYPES;
  assign addr    = AW'(typ);
  assign wprm    = '{k:   s_axis_tdata[146:115],
                     off: s_axis_tdata[178:147],
                     g:   s_axis_tdata[210:179],
                     cut: s_axis_tdata[242:211]};

  // the pipe only stalls when its tail holds a result the output cannot take
  assign out_load      = !m_axis_tvalid || m_axis_tready;
  assign adv           = out_load || !vf;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign we            = accept && (mode == MODE_LOAD) && type_ok;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
    end else if (cfg_valid && cfg_ready) begin
      radius <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[addr] <= 1'b1;
    end
  end

  sif_ram #(
    .WIDTH (PRM_W),
    .DEPTH (NUM_TYPES)
  ) u_tbl (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wprm),
    .re    (adv),
    .raddr (addr),
    .rdata (rprm)
  );

  // stage 1: request registered alongside the table read
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= accept && (mode == MODE_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx1    <= s_axis_tdata[15:0];
      pos1[0] <= s_axis_tdata[50:19];
      pos1[1] <= s_axis_tdata[82:51];
      pos1[2] <= s_axis_tdata[114:83];
      ok1     <= type_ok && vld[addr];
    end
  end

  always_comb begin
    ctx1 = '0;
    ctx1.idx = idx1;
    ctx1.on  = ok1 && !rprm.cut[POS_W-1];
    ctx1.prm = rprm;
    for (int c = 0; c < 3; c++) begin
      pm[c]          = pos1[c][POS_W-1] ? (~pos1[c] + 32'd1) : pos1[c];
      ctx1.neg[c]    = pos1[c][POS_W-1];
      ctx1.pmag[c]   = pm[c];
    end
  end

  // stage 2 squares, stage 3 sums
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx2 <= ctx1;
      for (int c = 0; c < 3; c++) begin
        sq2[c] <= pm[c] * pm[c];
      end
      ctx3 <= ctx2;
      r2_3 <= sq2[0] + sq2[1] + sq2[2];
    end
  end

  sif_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vin      (v3),
    .ctx_in   (ctx3),
    .rad_in   (r2_3),
    .vout     (vs),
    .ctx_out  (ctxs),
    .root_out (root_s)
  );

  // radial distance past the interface and branch choice
  always_comb begin
    base_d  = $signed({4'b0, radius}) +
              $signed({{3{ctxs.prm.off[POS_W-1]}}, ctxs.prm.off});
    rootv_d = $signed({3'b0, root_s});
    dr_d    = rootv_d - base_d;
    cut_d   = $signed({{3{ctxs.prm.cut[POS_W-1]}}, ctxs.prm.cut});
    ctxd_n      = ctxs;
    ctxd_n.r    = root_s;
    ctxd_n.dr   = dr_d;
    ctxd_n.live = ctxs.on && (root_s != '0) && !dr_d[DR_W-1];
    ctxd_n.harm = dr_d < cut_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (adv) begin
      vd <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctxd <= ctxd_n;
    end
  end

  sif_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .vin     (vd),
    .ctx_in  (ctxd),
    .vout    (vq),
    .ctx_out (ctxq),
    .q_out   (qv)
  );

  sif_force u_force (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .vin        (vq),
    .ctx_in     (ctxq),
    .q_in       (qv),
    .vout       (vf),
    .idx_out    (idxf),
    .force_out  (ff),
    .energy_out (ef)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      fsat[c] = ff[c][FV_W-1:FORCE_W-1] != {(FV_W-FORCE_W+1){ff[c][FORCE_W-1]}};
      if (fsat[c]) begin
        fclip[c] = ff[c][FV_W-1] ? {1'b1, {(FORCE_W-1){1'b0}}} : {1'b0, {(FORCE_W-1){1'b1}}};
      end else begin
        fclip[c] = ff[c][FORCE_W-1:0];
      end
    end
    esat = ef[EV_W-1:ENERGY_W-1] != {(EV_W-ENERGY_W+1){ef[ENERGY_W-1]}};
    if (esat) begin
      eclip = ef[EV_W-1] ? {1'b1, {(ENERGY_W-1){1'b0}}} : {1'b0, {(ENERGY_W-1){1'b1}}};
    end else begin
      eclip = ef[ENERGY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {eclip, fclip[2], fclip[1], fclip[0], idxf};
      m_axis_tuser <= (|fsat) || esat;
    end
  end

endmodule

`default_nettype wire

>>> src/sif_chk.sv
// port-level checks for the spherical interface wall force core
// depends on sif_pkg and the top level's ports; bound to it below
`default_nettype none

module sif_chk import sif_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  m_axis_tuser,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result after reset");

  // intake only backs up behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("intake stalled without output backpressure");

  // saturation flag implies some field sits at its limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[47:16] == 32'h7fffffff || m_axis_tdata[47:16] == 32'h80000000 ||
      m_axis_tdata[79:48] == 32'h7fffffff || m_axis_tdata[79:48] == 32'h80000000 ||
      m_axis_tdata[111:80] == 32'h7fffffff || m_axis_tdata[111:80] == 32'h80000000 ||
      m_axis_tdata[159:112] == 48'h7fffffffffff ||
      m_axis_tdata[159:112] == 48'h800000000000)
    else $error("saturated without a clipped field");

endmodule

bind spherical_interface_wall_force_core sif_chk u_sif_chk (.*);

`default_nettype wire

>>> test/spherical_interface_wall_force_core_tb.sv
// testbench for spherical_interface_wall_force_core: directed and random requests
// checked against an in-bench fixed point force model; depends on sif_pkg and the top level
`timescale 1ns / 100ps

module spherical_interface_wall_force_core_tb;
  import sif_pkg::*;

  localparam logic [63:0] MAG_LIMIT = 64'h4000000000000000;
  localparam longint      E_HI      = 64'sd140737488355327;
  localparam longint      E_LO      = -64'sd140737488355328;
  localparam int          SETTLE    = 100;

  typedef struct {
    logic [IDX_W-1:0]    idx;
    logic [31:0]         fx;
    logic [31:0]         fy;
    logic [31:0]         fz;
    logic [47:0]         en;
    logic                sat;
  } wall_result_t;

  logic                  clk;
  logic                  rst;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [RAD_W-1:0]      cfg_data;
  logic                  cfg_valid;
  logic                  cfg_ready;

  wall_result_t expected_forces[$];
  int           fail_count = 0;
  bit           calm;
  int           out_stall;

  // shadow copy of the per-type table and the radius register
  longint           tbl_k[8];
  longint           tbl_off[8];
  longint           tbl_g[8];
  longint           tbl_cut[8];
  logic [RAD_W-1:0] shell_radius;

  spherical_interface_wall_force_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_data      (cfg_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("spherical_interface_wall_force_core regression: fail");
    $finish;
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sign(a*b) * min(|a*b| >> s, limit), truncating
  function automatic longint mul_shift(longint a, longint b, int s);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    logic [63:0]  q;
    logic         neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = p >> s;
    if (p[127:64] != 0 || p[63:0] > MAG_LIMIT) q = MAG_LIMIT;
    else q = p[63:0];
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic longint clip_to(longint v, longint lo, longint hi, ref logic sat);
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  task automatic predict_wall(mode_t m, logic [15:0] idx, logic [2:0] ty,
                              fix_t px, fix_t py, fix_t pz,
                              fix_t k, fix_t off, fix_t g, fix_t cut);
    longint       pos[3];
    longint       force_c[3];
    longint       energy;
    longint       dr;
    longint       fmag;
    longint       u;
    logic [63:0]  r2;
    logic [63:0]  r;
    logic [63:0]  m_c;
    logic [63:0]  um;
    logic         sat;
    wall_result_t res;
    if (m == MODE_LOAD) begin
      tbl_k[ty] = k;
      tbl_off[ty] = off;
      tbl_g[ty] = g;
      tbl_cut[ty] = cut;
      return;
    end
    pos[0] = px;
    pos[1] = py;
    pos[2] = pz;
    force_c = '{0, 0, 0};
    energy = 0;
    sat = 1'b0;
    if (tbl_cut[ty] >= 0) begin
      r2 = 0;
      for (int c = 0; c < 3; c++) begin
        m_c = (pos[c] < 0) ? -pos[c] : pos[c];
        r2 = r2 + m_c * m_c;
      end
      r = root_floor(r2);
      dr = longint'(r) - (longint'({33'd0, shell_radius}) + tbl_off[ty]);
      if (r > 0 && dr >= 0) begin
        if (dr < tbl_cut[ty]) begin
          fmag = mul_shift(tbl_k[ty], dr, FRAC_BITS);
          // dr squared wraps at 64 bits like the fixed point original
          energy = mul_shift(tbl_k[ty], dr * dr, 2 * FRAC_BITS + 1);
        end else begin
          fmag = tbl_g[ty];
          energy = mul_shift(tbl_k[ty], tbl_cut[ty] * tbl_cut[ty], 2 * FRAC_BITS + 1)
                 + mul_shift(tbl_g[ty], dr - tbl_cut[ty], FRAC_BITS);
        end
        for (int c = 0; c < 3; c++) begin
          m_c = (pos[c] < 0) ? -pos[c] : pos[c];
          um = (m_c << FRAC_BITS) / r;
          u = (pos[c] < 0) ? -longint'(um) : longint'(um);
          force_c[c] = -mul_shift(fmag, u, FRAC_BITS);
        end
      end
    end
    for (int c = 0; c < 3; c++)
      force_c[c] = clip_to(force_c[c], -64'sd2147483648, 64'sd2147483647, sat);
    energy = clip_to(energy, E_LO, E_HI, sat);
    res.idx = idx;
    res.fx = force_c[0][31:0];
    res.fy = force_c[1][31:0];
    res.fz = force_c[2][31:0];
    res.en = energy[47:0];
    res.sat = sat;
    expected_forces.push_back(res);
  endtask

  task automatic send_item(mode_t m, logic [15:0] idx, logic [2:0] ty,
                           fix_t px, fix_t py, fix_t pz,
                           fix_t k, fix_t off, fix_t g, fix_t cut);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= m;
    s_axis_tdata <= {5'd0, cut, g, off, k, pz, py, px, ty, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_wall(m, idx, ty, px, py, pz, k, off, g, cut);
  endtask

  task automatic load_type(logic [2:0] ty, fix_t k, fix_t off, fix_t g, fix_t cut);
    send_item(MODE_LOAD, 16'($urandom), ty, $urandom, $urandom, $urandom, k, off, g, cut);
  endtask

  task automatic eval_at(logic [2:0] ty, fix_t px, fix_t py, fix_t pz);
    send_item(MODE_EVAL, 16'($urandom), ty, px, py, pz,
              $urandom, $urandom, $urandom, $urandom);
  endtask

  // drain results, then let trailing loads clear the pipeline
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_radius(logic [RAD_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shell_radius = v;
  endtask

  function automatic fix_t rand_small(int span_bits);
    return fix_t'($signed({1'b0, 31'($urandom_range(0, 2 ** span_bits))}) - 2 ** (span_bits - 1));
  endfunction

  task automatic test_reset_table_off();
    eval_at(3'd0, 32'sh00010000, 32'sh00020000, 32'sh00030000);
    eval_at(3'd7, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
  endtask

  task automatic test_directed();
    write_radius(31'd5 << 16);
    load_type(3'd0, 32'sh00020000, 32'sh00000000, 32'sh00010000, 32'sh00040000);
    load_type(3'd1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    load_type(3'd2, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000);
    load_type(3'd3, 32'sh00010000, 32'sh00000000, 32'sh00010000, 32'shFFFFFFFF);
    load_type(3'd4, 32'sh7FFFFFFF, 32'shFFFF0000, 32'sh7FFFFFFF, 32'sh00010000);
    // origin, inside, harmonic band, beyond cutoff
    eval_at(3'd0, 32'sh0, 32'sh0, 32'sh0);
    eval_at(3'd0, 32'sh00010000, 32'sh0, 32'sh0);
    eval_at(3'd0, 32'sh00060000, 32'sh0, 32'sh0);
    eval_at(3'd0, 32'sh0, 32'shFFF80000, 32'sh0);
    eval_at(3'd0, 32'sh00400000, 32'sh00400000, 32'shFFC00000);
    // saturating magnitudes and energy
    eval_at(3'd1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    eval_at(3'd1, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    eval_at(3'd2, 32'sh00100000, 32'sh0, 32'sh0);
    eval_at(3'd3, 32'sh00100000, 32'sh0, 32'sh0);
    eval_at(3'd4, 32'sh00080000, 32'shFFF00000, 32'sh7FFFFFFF);
    eval_at(3'd4, 32'sh0, 32'sh0, 32'sh80000000);
    send_item(MODE_EVAL, 16'hFFFF, 3'd7, 32'sh1, 32'sh1, 32'sh1, '0, '0, '0, '0);
    send_item(MODE_EVAL, 16'h0000, 3'd0, 32'sh7FFFFFFF, 32'sh0, 32'sh0, '1, '1, '1, '1);
    write_radius(31'h7FFFFFFF);
    eval_at(3'd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    eval_at(3'd1, 32'sh80000000, 32'sh0, 32'sh0);
    write_radius(31'd0);
    eval_at(3'd0, 32'sh00000001, 32'sh0, 32'sh0);
  endtask

  task automatic random_load();
    fix_t k;
    fix_t off;
    fix_t g;
    fix_t cut;
    k = ($urandom_range(0, 3) == 0) ? fix_t'($urandom) : rand_small(20);
    off = ($urandom_range(0, 3) == 0) ? fix_t'($urandom) : rand_small(19);
    g = ($urandom_range(0, 3) == 0) ? fix_t'($urandom) : rand_small(20);
    case ($urandom_range(0, 5))
      0: cut = fix_t'($urandom | 32'h80000000);
      1: cut = fix_t'($urandom);
      default: cut = fix_t'($urandom_range(0, 2 ** 22));
    endcase
    load_type(3'($urandom_range(0, 7)), k, off, g, cut);
  endtask

  task automatic random_eval();
    logic [2:0] ty;
    longint     target;
    fix_t       p[3];
    int         ax;
    ty = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0: p = '{fix_t'($urandom), fix_t'($urandom), fix_t'($urandom)};
      1: p = '{rand_small(22), rand_small(22), rand_small(22)};
      2: p = '{0, 0, 0};
      default: begin
        // close to the shell of this type, mostly along one axis
        target = longint'({33'd0, shell_radius}) + tbl_off[ty]
               + $urandom_range(0, 2 ** 21) - 2 ** 16;
        if (target > 64'sd2147483647) target = 64'sd2147483647;
        if (target < 0) target = -target;
        ax = $urandom_range(0, 2);
        p = '{rand_small(12), rand_small(12), rand_small(12)};
        p[ax] = $urandom_range(0, 1) ? fix_t'(target) : fix_t'(-target);
      end
    endcase
    send_item(MODE_EVAL, 16'($urandom), ty, p[0], p[1], p[2],
              $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic test_random(logic [RAD_W-1:0] radius, int count, bit quiet);
    write_radius(radius);
    calm = quiet;
    for (int t = 0; t < 8; t++) random_load();
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 6) == 0) random_load();
      else random_eval();
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      m_axis_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) out_stall <= gap_len();
    end
  end

  always @(posedge clk) begin
    wall_result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_forces.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        e = expected_forces.pop_front();
        if (m_axis_tdata[15:0] !== e.idx || m_axis_tdata[47:16] !== e.fx ||
            m_axis_tdata[79:48] !== e.fy || m_axis_tdata[111:80] !== e.fz ||
            m_axis_tdata[159:112] !== e.en || m_axis_tuser !== e.sat) begin
          $display("%0t: mismatch exp idx %h f %h %h %h e %h sat %b", $time,
                   e.idx, e.fx, e.fy, e.fz, e.en, e.sat);
          $display("%0t:          got idx %h f %h %h %h e %h sat %b", $time,
                   m_axis_tdata[15:0], m_axis_tdata[47:16], m_axis_tdata[79:48],
                   m_axis_tdata[111:80], m_axis_tdata[159:112], m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tvalid = 1'b0;
    cfg_data = '0;
    cfg_valid = 1'b0;
    calm = 1'b0;
    shell_radius = '0;
    for (int t = 0; t < 8; t++) begin
      tbl_k[t] = 0;
      tbl_off[t] = 0;
      tbl_g[t] = 0;
      tbl_cut[t] = -1;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_table_off();
    test_directed();
    test_random(31'd0, 300, 1'b1);
    test_random(31'd5 << 16, 400, 1'b0);
    test_random(31'($urandom), 400, 1'b0);
    test_random(31'h7FFFFFFF, 300, 1'b0);
    test_random(31'($urandom_range(1, 2 ** 24)), 400, 1'b0);
    settle();
    if (fail_count == 0 && expected_forces.size() == 0) begin
      $display("spherical_interface_wall_force_core regression: pass");
    end else begin
      $display("spherical_interface_wall_force_core regression: fail");
    end
    $finish;
  end

endmodule
